// ----- design/palette_fade_engine_core_assert.svh -----
// ----------------------------------------------------------------------------
// palette fade engine assertion macros
// shared concurrent check forms, clocked on clk_i and off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef PALETTE_FADE_ENGINE_CORE_ASSERT_SVH
`define PALETTE_FADE_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define PFE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg
// operation codes, controller states, command and status bundles and the
// component clamp shared by the palette fade engine modules
// ----------------------------------------------------------------------------
package pfe_pkg;

  // longest run of colors one tick walks
  localparam int unsigned MAX_RUN   = 16;
  localparam int unsigned COMP_W    = 8;
  localparam int unsigned CHAN_W    = 5;
  localparam int unsigned COLOR_W   = 15;
  localparam int unsigned PIDX_W    = 9;
  localparam int unsigned SLOT_W    = 4;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SET   = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLEAR = 4'b0010,
    S_STEP  = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic col_rd;  // read the color at the next slot
    logic col_wr;  // write back stepped color and load output register
    logic clr_wr;  // clearing pass write
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tick_go;    // pending item is a tick on an existing bank
    logic step_nz;    // step fetched for the tick is nonzero
    logic out_free;   // output register can take a new color
    logic slot_zero;  // held color is slot 0
    logic clr_last;   // clearing pass at the final entry
  } sts_t;

  // biased component read as signed, minus 32, clamped to 0..31
  function automatic logic [CHAN_W-1:0] clamp_comp(input logic [COMP_W-1:0] c);
    logic [CHAN_W-1:0] res;
    if (c[7] || (c[6:5] == 2'b00)) begin
      res = '0;
    end else if (c[6]) begin
      res = '1;
    end else begin
      res = c[4:0];
    end
    return res;
  endfunction

endpackage

// ----- design/pfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfe_ctrl
// controller FSM: memory clearing pass after reset, input acceptance,
// step fetch and, while output is free, the one-color-per-cycle tick walk
// ----------------------------------------------------------------------------
`include "palette_fade_engine_core_assert.svh"

module pfe_ctrl
  import pfe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.tick_go) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (sts_i.step_nz) begin
          cmd_o.col_rd = 1'b1;
          state_d      = S_WRITE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.col_wr = 1'b1;
          if (sts_i.slot_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.col_rd = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register, clearing pass starts out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `PFE_ASSERT_IMPL(a_wr_needs_room, cmd_o.col_wr, sts_i.out_free,
                   "color written back while output register is busy")
  `PFE_ASSERT_NEXT(a_run_ends, cmd_o.col_wr && sts_i.slot_zero, state_q == S_IDLE,
                   "tick run did not end after slot 0")
  `PFE_ASSERT_IMPL(a_step_after_tick, state_q == S_STEP,
                   $past(cmd_o.accept && sts_i.tick_go),
                   "step fetch without an accepted tick")

endmodule

// ----- design/pfe_dp.sv -----
// ----------------------------------------------------------------------------
// pfe_dp
// datapath: bank step store, color component store, read-modify-write of
// stepped colors, clamp and pack, output register
// ----------------------------------------------------------------------------
`include "palette_fade_engine_core_assert.svh"

module pfe_dp
  import pfe_pkg::*;
#(
  parameter int unsigned NUM_BANKS       = 32,
  parameter int unsigned COLORS_PER_BANK = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [1:0]          operation_i,
  input  logic [4:0]          bank_i,
  input  logic [SLOT_W-1:0]   color_slot_i,
  input  logic [COLOR_W-1:0]  source_color_i,
  input  logic [1:0]          start_bias_i,
  input  logic signed [7:0]   step_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [PIDX_W-1:0]   palette_index_o,
  output logic [COLOR_W-1:0]  color_value_o,
  output logic                last_o
);

  localparam int unsigned NUM_COLORS = NUM_BANKS * COLORS_PER_BANK;
  localparam int unsigned AW = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
  localparam int unsigned BW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int unsigned RUN = (COLORS_PER_BANK < MAX_RUN) ? COLORS_PER_BANK : MAX_RUN;
  localparam logic [SLOT_W-1:0] RUN_LAST = SLOT_W'(RUN - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_COLORS - 1);

  // input decode
  logic          bank_ok, slot_ok;
  logic          is_load, is_set, is_clr, is_tick;
  logic [BW-1:0] bank_idx;
  logic [AW-1:0] load_addr, tick_base;

  assign bank_ok  = 32'(bank_i) < NUM_BANKS;
  assign slot_ok  = 32'(color_slot_i) < COLORS_PER_BANK;
  assign bank_idx = BW'(bank_i);
  assign tick_base = AW'(32'(bank_i) * COLORS_PER_BANK);
  assign load_addr = AW'(32'(bank_i) * COLORS_PER_BANK + 32'(color_slot_i));

  assign is_load = cmd_i.accept && (operation_i == OP_LOAD) && bank_ok && slot_ok;
  assign is_set  = cmd_i.accept && (operation_i == OP_SET) && bank_ok;
  assign is_clr  = cmd_i.accept && (operation_i == OP_CLEAR);
  assign is_tick = cmd_i.accept && (operation_i == OP_TICK) && bank_ok;

  // bank step store, valid bits give the cleared value
  logic [7:0]           step_mem [NUM_BANKS];
  logic [NUM_BANKS-1:0] step_vld_q;
  logic [7:0]           step_rd_q;
  logic                 step_vld_rd_q;
  logic [7:0]           step_eff;

  always_ff @(posedge clk_i) begin
    if (is_load || is_set) begin
      step_mem[bank_idx] <= step_i;
    end
    if (is_tick) begin
      step_rd_q <= step_mem[bank_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_vld_q    <= '0;
      step_vld_rd_q <= 1'b0;
    end else begin
      if (is_clr) begin
        step_vld_q <= '0;
      end else if (is_load || is_set) begin
        step_vld_q[bank_idx] <= 1'b1;
      end
      if (is_tick) begin
        step_vld_rd_q <= step_vld_q[bank_idx];
      end
    end
  end

  assign step_eff = step_vld_rd_q ? step_rd_q : 8'd0;

  // tick walk position
  logic [AW-1:0]     base_q;
  logic [SLOT_W-1:0] slot_q, slot_nxt;
  logic [AW-1:0]     rd_addr_d, rd_addr_q;

  assign slot_nxt  = cmd_i.col_wr ? slot_q - SLOT_W'(1) : slot_q;
  assign rd_addr_d = base_q + AW'(slot_nxt);

  always_ff @(posedge clk_i) begin
    if (is_tick) begin
      base_q <= tick_base;
      slot_q <= RUN_LAST;
    end else if (cmd_i.col_wr) begin
      slot_q <= slot_q - SLOT_W'(1);
    end
  end

  // clearing pass counter
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  // load unpack with start bias
  logic [7:0]  bias;
  logic [23:0] load_data;

  assign bias      = 8'({start_bias_i, 5'b00000});
  assign load_data = {8'({3'b000, source_color_i[14:10]}) + bias,
                      8'({3'b000, source_color_i[9:5]}) + bias,
                      8'({3'b000, source_color_i[4:0]}) + bias};

  // stepped color, components packed blue, green, red
  logic [23:0] rd_data_q;
  logic [7:0]  red_s, grn_s, blu_s;
  logic [23:0] step_data;

  assign red_s     = rd_data_q[7:0] + step_eff;
  assign grn_s     = rd_data_q[15:8] + step_eff;
  assign blu_s     = rd_data_q[23:16] + step_eff;
  assign step_data = {blu_s, grn_s, red_s};

  // color store write port select
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [23:0]   mem_wd;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = load_addr;
    mem_wd = load_data;
    if (cmd_i.clr_wr) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q;
      mem_wd = '0;
    end else if (cmd_i.col_wr) begin
      mem_we = 1'b1;
      mem_wa = rd_addr_q;
      mem_wd = step_data;
    end else if (is_load) begin
      mem_we = 1'b1;
    end
  end

  // color component store
  logic [23:0] col_mem [NUM_COLORS];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      col_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.col_rd) begin
      rd_data_q <= col_mem[rd_addr_d];
      rd_addr_q <= rd_addr_d;
    end
  end

  // output register
  logic                out_valid_q;
  logic [PIDX_W-1:0]   pidx_q;
  logic [COLOR_W-1:0]  color_q;
  logic                last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.col_wr) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.col_wr) begin
      pidx_q  <= PIDX_W'(rd_addr_q);
      color_q <= {clamp_comp(blu_s), clamp_comp(grn_s), clamp_comp(red_s)};
      last_q  <= (slot_q == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign palette_index_o = pidx_q;
  assign color_value_o   = color_q;
  assign last_o          = last_q;

  // status to controller
  assign sts_o.tick_go   = (operation_i == OP_TICK) && bank_ok;
  assign sts_o.step_nz   = step_eff != 8'd0;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.slot_zero = slot_q == '0;
  assign sts_o.clr_last  = clr_cnt_q == LAST_ADDR;

  `PFE_ASSERT_NEXT(a_out_no_repeat, out_valid_q && !out_stall_i && !cmd_i.col_wr,
                   !out_valid_q, "delivered color shown again")

endmodule

// ----- design/palette_fade_engine_core.sv -----
// Tick: the step is registered on acceptance, the first color is read in S_STEP, then
// S_WRITE writes back and outputs one color per cycle while the output is not stalled;
// the color store read-modify-write port sets that pace, and the input is held until
// slot 0 is written. Load, set and clear do not stall; a zero-step tick ends in S_STEP.
// Reset: step valid bits clear at once; the color store is then cleared one
// entry per cycle (NUM_BANKS*COLORS_PER_BANK entries, 512 by default), in_stall_o high.
// ----------------------------------------------------------------------------
// palette_fade_engine_core
// palette fade engine top level: controller plus datapath
// ----------------------------------------------------------------------------
module palette_fade_engine_core
  import pfe_pkg::*;
#(
  parameter int unsigned NUM_BANKS       = 32,
  parameter int unsigned COLORS_PER_BANK = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [4:0]          bank_i,
  input  logic [SLOT_W-1:0]   color_slot_i,
  input  logic [COLOR_W-1:0]  source_color_i,
  input  logic [1:0]          start_bias_i,
  input  logic signed [7:0]   step_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PIDX_W-1:0]   palette_index_o,
  output logic [COLOR_W-1:0]  color_value_o,
  output logic                last_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  pfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stores, arithmetic and output register
  pfe_dp #(
    .NUM_BANKS       (NUM_BANKS),
    .COLORS_PER_BANK (COLORS_PER_BANK)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .operation_i     (operation_i),
    .bank_i          (bank_i),
    .color_slot_i    (color_slot_i),
    .source_color_i  (source_color_i),
    .start_bias_i    (start_bias_i),
    .step_i          (step_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .palette_index_o (palette_index_o),
    .color_value_o   (color_value_o),
    .last_o          (last_o)
  );

endmodule
